>>> src/sfr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the stuffed frame receiver.
// No dependencies; every other file of the block imports this package.
package sfr_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_START  = 3'd0;
  localparam logic [2:0] REG_END    = 3'd1;
  localparam logic [2:0] REG_ESCAPE = 3'd2;
  localparam logic [2:0] REG_XON    = 3'd3;
  localparam logic [2:0] REG_XOFF   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0] START_RST  = 8'h02;
  localparam logic [7:0] END_RST    = 8'h03;
  localparam logic [7:0] ESCAPE_RST = 8'h10;
  localparam logic [7:0] XON_RST    = 8'h11;
  localparam logic [7:0] XOFF_RST   = 8'h13;

  // Frame bound and byte counter width.
  localparam int unsigned CNT_W = 8;
  localparam logic [CNT_W-1:0] MAX_FRAME = 8'd128;

  // CRC and unstuffing constants.
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [7:0]  UNSTUFF_OFFSET = 8'h40;

  // Closing result error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ESC  = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  // Operation codes passed from the front to the back.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;
  localparam int unsigned Q_CW    = 2;

  // One classified item for the back end.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       esc;
  } op_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte per call.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> src/sfr_front.sv
// Front end: configuration registers, frame and escape tracking, byte classification.
// Depends on sfr_pkg; pushes one operation per meaningful byte into the queue.
module sfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [7:0]    cfg_wdata,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output sfr_pkg::op_t  push_op
);
  import sfr_pkg::*;

  logic [7:0] start_r, end_r, escape_r, xon_r, xoff_r;
  logic       in_frame_r, in_frame_nxt;
  logic       esc_r, esc_nxt;
  logic       is_prefix;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= START_RST;
      end_r    <= END_RST;
      escape_r <= ESCAPE_RST;
      xon_r    <= XON_RST;
      xoff_r   <= XOFF_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START:  start_r  <= cfg_wdata;
        REG_END:    end_r    <= cfg_wdata;
        REG_ESCAPE: escape_r <= cfg_wdata;
        REG_XON:    xon_r    <= cfg_wdata;
        REG_XOFF:   xoff_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign is_prefix = (rx_byte == escape_r) || (rx_byte == xon_r) ||
                     (rx_byte == xoff_r) || (rx_byte == start_r);

  // Classify the byte against the frame and escape state.
  always_comb begin
    in_frame_nxt  = in_frame_r;
    esc_nxt       = esc_r;
    push          = 1'b0;
    push_op.op    = OP_DATA;
    push_op.data  = rx_byte;
    push_op.esc   = esc_r;
    if (accept) begin
      if (!in_frame_r) begin
        if (rx_byte == start_r) begin
          push         = 1'b1;
          push_op.op   = OP_START;
          in_frame_nxt = 1'b1;
          esc_nxt      = 1'b0;
        end
      end else if (rx_byte == end_r) begin
        push         = 1'b1;
        push_op.op   = OP_END;
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
      end else if (esc_r) begin
        push         = 1'b1;
        push_op.data = rx_byte - UNSTUFF_OFFSET;
        esc_nxt      = 1'b0;
      end else if (is_prefix) begin
        esc_nxt = 1'b1;
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
    end
  end

endmodule

>>> src/sfr_queue.sv
// Short register queue that decouples the classifying front from the back end.
// Depends on sfr_pkg for the operation type and depth constants.
module sfr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sfr_pkg::op_t       push_op,
  input  logic               pop,
  output sfr_pkg::op_t       head_op,
  output sfr_pkg::q_status_t status
);
  import sfr_pkg::*;

  op_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r;

  assign head_op      = mem_r[rd_ptr_r];
  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == Q_CW'(Q_DEPTH));

  // Entry storage; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> src/sfr_back.sv
// Back end: CRC-16, frame byte count, overflow tracking and the output register.
// Depends on sfr_pkg; consumes operations from the queue head.
module sfr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sfr_pkg::op_t       head_op,
  input  sfr_pkg::q_status_t q_status,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [7:0]         out_data_byte,
  output logic               out_is_data,
  output logic               out_frame_end,
  output logic               out_crc_good,
  output logic [1:0]         out_error_code
);
  import sfr_pkg::*;

  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             is_data_r, is_data_nxt;
  logic             end_r, end_nxt;
  logic             good_r, good_nxt;
  logic [1:0]       err_r, err_nxt;
  logic             produce;

  // Take the next operation whenever the output register is free or draining.
  assign pop = q_status.valid && (!valid_r || !out_stall);

  always_comb begin
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    produce     = 1'b0;
    data_nxt    = data_r;
    is_data_nxt = is_data_r;
    end_nxt     = end_r;
    good_nxt    = good_r;
    err_nxt     = err_r;
    if (pop) begin
      case (head_op.op)
        OP_START: begin
          crc_nxt   = crc16_byte(16'h0000, head_op.data);
          count_nxt = CNT_W'(1);
          ovf_nxt   = 1'b0;
        end
        OP_DATA: begin
          if (count_r >= MAX_FRAME) begin
            ovf_nxt = 1'b1;
          end else begin
            crc_nxt     = crc16_byte(crc_r, head_op.data);
            count_nxt   = count_r + 1'b1;
            produce     = 1'b1;
            data_nxt    = head_op.data;
            is_data_nxt = 1'b1;
            end_nxt     = 1'b0;
            good_nxt    = 1'b0;
            err_nxt     = ERR_NONE;
          end
        end
        OP_END: begin
          produce     = 1'b1;
          data_nxt    = 8'h00;
          is_data_nxt = 1'b0;
          end_nxt     = 1'b1;
          good_nxt    = (crc_r == 16'h0000);
          err_nxt     = ovf_r ? ERR_OVF : (head_op.esc ? ERR_ESC : ERR_NONE);
          crc_nxt     = '0;
          count_nxt   = '0;
          ovf_nxt     = 1'b0;
        end
        default: ;
      endcase
    end
    valid_nxt = produce || (valid_r && out_stall);
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    is_data_r <= is_data_nxt;
    end_r     <= end_nxt;
    good_r    <= good_nxt;
    err_r     <= err_nxt;
  end

  assign out_valid      = valid_r;
  assign out_data_byte  = data_r;
  assign out_is_data    = is_data_r;
  assign out_frame_end  = end_r;
  assign out_crc_good   = good_r;
  assign out_error_code = err_r;

endmodule

>>> src/stuffed_frame_receiver_crc16_core.sv
// Top level of the stuffed frame receiver with CRC-16 check.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   in      | input     | in_valid, in_stall, in_rx_byte
//   out     | output    | out_valid, out_stall, out_data_byte, out_is_data,
//           |           | out_frame_end, out_crc_good, out_error_code
//   cfg     | input     | cfg_we, cfg_idx, cfg_wdata (write only)
//
// One item per cycle is accepted while in_stall is low; the front classifies each item into the
// queue, and the back then updates the CRC and loads the output register from the queue head.
// The two-entry queue raises in_stall only when it is full, i.e. the output side stalls.
// Reset is synchronous, active low, and clears codes to defaults and all frame state.
module stuffed_frame_receiver_crc16_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_is_data,
  output logic       out_frame_end,
  output logic       out_crc_good,
  output logic [1:0] out_error_code
);
  import sfr_pkg::*;

  logic      accept;
  logic      push;
  logic      pop;
  op_t       push_op;
  op_t       head_op;
  q_status_t q_status;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Classification of incoming bytes.
  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .push      (push),
    .push_op   (push_op)
  );

  // Decoupling queue.
  sfr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (q_status)
  );

  // CRC, count and result generation.
  sfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_op        (head_op),
    .q_status       (q_status),
    .pop            (pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_data_byte  (out_data_byte),
    .out_is_data    (out_is_data),
    .out_frame_end  (out_frame_end),
    .out_crc_good   (out_crc_good),
    .out_error_code (out_error_code)
  );

`ifndef SYNTHESIS
  // A full queue always has a head to offer.
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> q_status.valid)
    else $error("queue reports full without a valid head");

  // A result is either data or a frame close, never both.
  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_data != out_frame_end))
    else $error("result kind is not exactly one of data and frame end");

  // Data results carry no status.
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_data) |-> (!out_crc_good && out_error_code == ERR_NONE))
    else $error("data result carries status bits");

  // Nothing is popped from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_status.valid)
    else $error("pop from empty queue");
`endif

endmodule

>>> dv/sfr_frame_checker.sv
// Checker for the stuffed frame receiver: watches the config port and both item channels.
// Predicts each closing or data result from the accepted line bytes and compares them in order.
// Depends on sfr_pkg for register indexes, error codes and the frame bound.
module sfr_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_data_byte,
  input  logic       out_is_data,
  input  logic       out_frame_end,
  input  logic       out_crc_good,
  input  logic [1:0] out_error_code,
  output int         fail_count,
  output int         pending
);
  import sfr_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
    logic       frame_end;
    logic       crc_good;
    logic [1:0] error_code;
  } frame_result_t;

  frame_result_t pending_frame_results[$];

  // Code bytes as last written through the config port.
  logic [7:0] code_start, code_end, code_escape, code_xon, code_xoff;

  // Frame decoder state.
  logic             frame_open;
  logic             prefix_seen;
  logic             bound_hit;
  logic [15:0]      crc_acc;
  logic [CNT_W-1:0] kept_count;

  // CRC-16 over one byte, MSB first, no reflection.
  function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // Decode one accepted line byte and queue the result it causes, if any.
  task automatic unstuff_and_check(input logic [7:0] b);
    logic [7:0]    decoded;
    logic          keep;
    frame_result_t res;
    decoded = b;
    keep = 1'b1;
    if (!frame_open) begin
      // Outside a frame only the start code matters.
      if (b == code_start) begin
        frame_open  = 1'b1;
        prefix_seen = 1'b0;
        bound_hit   = 1'b0;
        crc_acc     = crc_fold_byte(16'h0000, b);
        kept_count  = CNT_W'(1);
      end
    end else if (b == code_end) begin
      // Closing result; overflow wins over a dangling prefix.
      res.data_byte  = 8'h00;
      res.is_data    = 1'b0;
      res.frame_end  = 1'b1;
      res.crc_good   = (crc_acc == 16'h0000);
      res.error_code = bound_hit ? ERR_OVF : (prefix_seen ? ERR_ESC : ERR_NONE);
      pending_frame_results.push_back(res);
      frame_open  = 1'b0;
      prefix_seen = 1'b0;
      bound_hit   = 1'b0;
      crc_acc     = 16'h0000;
      kept_count  = '0;
    end else begin
      if (prefix_seen) begin
        prefix_seen = 1'b0;
        decoded = b - UNSTUFF_OFFSET;
      end else if (b == code_escape || b == code_xon || b == code_xoff || b == code_start) begin
        prefix_seen = 1'b1;
        keep = 1'b0;
      end
      if (keep) begin
        if (kept_count >= MAX_FRAME) begin
          bound_hit = 1'b1;
        end else begin
          crc_acc = crc_fold_byte(crc_acc, decoded);
          kept_count = kept_count + 1'b1;
          res.data_byte  = decoded;
          res.is_data    = 1'b1;
          res.frame_end  = 1'b0;
          res.crc_good   = 1'b0;
          res.error_code = ERR_NONE;
          pending_frame_results.push_back(res);
        end
      end
    end
  endtask

  // Sample everything at the clock edge: config, input item, then result item.
  always @(posedge clk) begin
    frame_result_t seen, want;
    if (!rst_n) begin
      code_start  = START_RST;
      code_end    = END_RST;
      code_escape = ESCAPE_RST;
      code_xon    = XON_RST;
      code_xoff   = XOFF_RST;
      frame_open  = 1'b0;
      prefix_seen = 1'b0;
      bound_hit   = 1'b0;
      crc_acc     = 16'h0000;
      kept_count  = '0;
      fail_count  = 0;
      pending_frame_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_START:  code_start  = cfg_wdata;
          REG_END:    code_end    = cfg_wdata;
          REG_ESCAPE: code_escape = cfg_wdata;
          REG_XON:    code_xon    = cfg_wdata;
          REG_XOFF:   code_xoff   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        unstuff_and_check(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        seen.data_byte  = out_data_byte;
        seen.is_data    = out_is_data;
        seen.frame_end  = out_frame_end;
        seen.crc_good   = out_crc_good;
        seen.error_code = out_error_code;
        if (pending_frame_results.size() == 0) begin
          $display("%0t: unexpected result item: data=%h is_data=%b end=%b good=%b err=%0d",
                   $time, seen.data_byte, seen.is_data, seen.frame_end, seen.crc_good,
                   seen.error_code);
          fail_count++;
        end else begin
          want = pending_frame_results.pop_front();
          if (seen !== want) begin
            $display("%0t: mismatch: expected data=%h is_data=%b end=%b good=%b err=%0d",
                     $time, want.data_byte, want.is_data, want.frame_end, want.crc_good,
                     want.error_code);
            $display("%0t:           actual   data=%h is_data=%b end=%b good=%b err=%0d",
                     $time, seen.data_byte, seen.is_data, seen.frame_end, seen.crc_good,
                     seen.error_code);
            fail_count++;
          end
        end
      end
    end
    pending <= pending_frame_results.size();
  end

endmodule

>>> dv/tb_stuffed_frame_receiver_crc16_core.sv
// Testbench top for stuffed_frame_receiver_crc16_core: clock, reset, config writes and stimulus.
// Builds stuffed frames with CRC trailers, broken frames and noise; sfr_frame_checker judges.
// Depends on sfr_pkg, the block and sfr_frame_checker.
module tb_stuffed_frame_receiver_crc16_core;
  import sfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 155;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_idx   = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_is_data;
  logic       out_frame_end;
  logic       out_crc_good;
  logic [1:0] out_error_code;
  int         fail_count;
  int         pending;

  // Idling controls for the sender and the receiver.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  bit hold_served   = 1'b0;

  // Codes as written, used to build frames.
  logic [7:0] cur_start = START_RST;
  logic [7:0] cur_end   = END_RST;
  logic [7:0] cur_esc   = ESCAPE_RST;
  logic [7:0] cur_xon   = XON_RST;
  logic [7:0] cur_xoff  = XOFF_RST;

  // Line bytes of the sequence being sent.
  logic [7:0] line_q[$];

  stuffed_frame_receiver_crc16_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_is_data    (out_is_data),
    .out_frame_end  (out_frame_end),
    .out_crc_good   (out_crc_good),
    .out_error_code (out_error_code)
  );

  sfr_frame_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_is_data    (out_is_data),
    .out_frame_end  (out_frame_end),
    .out_crc_good   (out_crc_good),
    .out_error_code (out_error_code),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: too many cycles without any accepted item ends the run.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: watchdog expired", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  // CRC-16 of the frame so far, bit by bit, to build a trailer that leaves zero.
  function automatic logic [15:0] trailer_crc(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic bit is_code(input logic [7:0] v);
    return (v == cur_start || v == cur_end || v == cur_esc || v == cur_xon || v == cur_xoff);
  endfunction

  // Pick a prefix byte that will not be taken for the end code.
  function automatic bit pick_prefix(output logic [7:0] p);
    logic [7:0] cand[$];
    p = cur_esc;
    if (cur_esc != cur_end) cand.push_back(cur_esc);
    if (cur_xon != cur_end) cand.push_back(cur_xon);
    if (cur_xoff != cur_end) cand.push_back(cur_xoff);
    if (cur_start != cur_end) cand.push_back(cur_start);
    if (cand.size() == 0) return 1'b0;
    p = cand[$urandom_range(cand.size() - 1)];
    return 1'b1;
  endfunction

  // Append one decoded byte to the line, stuffed when it collides with a code.
  task automatic push_stuffed(input logic [7:0] d);
    logic [7:0] p;
    if (is_code(d) && pick_prefix(p)) begin
      line_q.push_back(p);
      line_q.push_back(d + UNSTUFF_OFFSET);
    end else begin
      line_q.push_back(d);
    end
  endtask

  // Offer one item and wait until it is accepted.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_line(inout int sent);
    while (line_q.size() > 0) begin
      send_byte(line_q.pop_front());
      sent++;
    end
  endtask

  // Build a frame: 0 good CRC, 1 bad CRC, 2 dangling prefix, 3 left open.
  task automatic build_frame(input int len, input int kind);
    logic [15:0] crc;
    logic [7:0]  d, shifted, p;
    line_q.push_back(cur_start);
    crc = trailer_crc(16'h0000, cur_start);
    for (int i = 0; i < len; i++) begin
      do begin
        d = 8'($urandom_range(255));
        shifted = d + UNSTUFF_OFFSET;
      end while (is_code(d) && shifted == cur_end);
      crc = trailer_crc(crc, d);
      push_stuffed(d);
    end
    case (kind)
      0, 1: begin
        if (kind == 1) crc = crc ^ 16'($urandom_range(65535, 1));
        push_stuffed(crc[15:8]);
        push_stuffed(crc[7:0]);
        line_q.push_back(cur_end);
      end
      2: begin
        if (pick_prefix(p)) line_q.push_back(p);
        line_q.push_back(cur_end);
      end
      default: ;
    endcase
  endtask

  // One random sequence: mostly well-formed frames, some broken ones and noise.
  task automatic run_sequence(inout int sent);
    int pick, len;
    pick = $urandom_range(99);
    len = ($urandom_range(99) < 8) ? $urandom_range(140, 120) : $urandom_range(12);
    if (pick < 60) build_frame(len, 0);
    else if (pick < 70) build_frame(len, 1);
    else if (pick < 80) build_frame(len, 2);
    else if (pick < 88) build_frame(len, 3);
    else begin
      repeat ($urandom_range(6, 1)) line_q.push_back(8'($urandom_range(255)));
    end
    send_line(sent);
  endtask

  // Config write, one register per cycle; the caller lowers cfg_we afterwards.
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_START:  cur_start = val;
      REG_END:    cur_end   = val;
      REG_ESCAPE: cur_esc   = val;
      REG_XON:    cur_xon   = val;
      REG_XOFF:   cur_xoff  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x,
                             input logic [7:0] on, input logic [7:0] off);
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    write_reg(REG_ESCAPE, x);
    write_reg(REG_XON, on);
    write_reg(REG_XOFF, off);
  endtask

  // Stop offering items and let every result and any item in flight drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Main stimulus: directed items on reset codes, then phases of random frames.
  initial begin
    int sent;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: begin
            write_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
            // Indexes past the last register must be ignored.
            write_reg(3'd5, 8'hFF);
            write_reg(3'd6, 8'h00);
            write_reg(3'd7, 8'($urandom_range(255)));
          end
          2: write_codes(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h7F);
          3: write_codes(8'hFF, 8'h00, 8'h80, 8'h40, 8'hBF);
          4: write_codes(8'h7E, 8'h7E, 8'h7D, 8'h7D, 8'h7D);
          5: write_codes(START_RST, END_RST, ESCAPE_RST, XON_RST, XOFF_RST);
          default: begin
            write_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
          end
        endcase
        cfg_we <= 1'b0;
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      sent = 0;
      if (phase == 4) hold_req = 1'b1;
      if (phase == 0) begin
        // End code outside a frame, noise, then every prefix kind and a dangling prefix.
        line_q = '{8'h03, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h10, 8'h50, 8'h11, 8'h51,
                   8'h13, 8'h53, 8'h02, 8'h42, 8'h10, 8'h03};
        send_line(sent);
        build_frame(2, 0);
        send_line(sent);
      end
      while (sent < ITEMS_PER_PHASE) run_sequence(sent);
    end
    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
